[sv/peq_pkg.sv]
// Shared types and constants for the pointer event queue.
// No dependencies; imported by peq_wheel_div and pointer_event_queue_unit.
`timescale 1ns / 1ps

package peq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int KIND_W  = 4;
   localparam int TYPE_W  = 4;
   localparam int COORD_W = 16;
   localparam int WHEEL_W = 16;
   localparam int STEP_W  = 15;
   localparam int QUO_W   = 16;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_MOVE     = 4'd0;
   localparam logic [KIND_W-1:0] KIND_LPRESS   = 4'd1;
   localparam logic [KIND_W-1:0] KIND_LRELEASE = 4'd2;
   localparam logic [KIND_W-1:0] KIND_RPRESS   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_RRELEASE = 4'd4;
   localparam logic [KIND_W-1:0] KIND_ENTER    = 4'd5;
   localparam logic [KIND_W-1:0] KIND_LEAVE    = 4'd6;
   localparam logic [KIND_W-1:0] KIND_WHEEL    = 4'd7;
   localparam logic [KIND_W-1:0] KIND_READ     = 4'd8;
   localparam logic [KIND_W-1:0] KIND_FLUSH    = 4'd9;

   // queued event types
   localparam logic [TYPE_W-1:0] EVT_MOVE       = 4'd0;
   localparam logic [TYPE_W-1:0] EVT_LPRESS     = 4'd1;
   localparam logic [TYPE_W-1:0] EVT_LRELEASE   = 4'd2;
   localparam logic [TYPE_W-1:0] EVT_RPRESS     = 4'd3;
   localparam logic [TYPE_W-1:0] EVT_RRELEASE   = 4'd4;
   localparam logic [TYPE_W-1:0] EVT_SCROLLUP   = 4'd5;
   localparam logic [TYPE_W-1:0] EVT_SCROLLDOWN = 4'd6;
   localparam logic [TYPE_W-1:0] EVT_ENTER      = 4'd7;
   localparam logic [TYPE_W-1:0] EVT_LEAVE      = 4'd8;

   localparam logic [STEP_W-1:0] WHEEL_STEP_RESET = 15'd120;

   typedef struct packed {
      logic [TYPE_W-1:0]  event_type;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               left;
      logic               right;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quotient;
      logic [STEP_W-1:0] remainder;
   } div_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUSH,
      ST_READ
   } state_type;

endpackage

[sv/peq_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
`timescale 1ns / 1ps

module peq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/peq_wheel_div.sv]
// Restoring divider, one quotient bit per cycle, for the wheel step count.
// Depends on peq_pkg.
`timescale 1ns / 1ps

module peq_wheel_div
   import peq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [QUO_W-1:0]    dividend,
   input  logic [STEP_W-1:0]   divisor,
   output div_status_type      status
);

   localparam int ITER_W = $clog2(QUO_W);

   logic                run_ff,  run_in;
   logic                done_ff, done_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   logic [STEP_W-1:0]   rem_ff,  rem_in;
   logic [QUO_W-1:0]    quo_ff,  quo_in;
   logic [STEP_W-1:0]   div_ff,  div_in;
   logic [STEP_W:0]     shifted;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[QUO_W-1]};
      fits    = shifted >= {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         run_in  = 1'b1;
         iter_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (run_ff) begin
         // remainder stays below the divisor, so it fits back in STEP_W bits
         rem_in  = fits ? STEP_W'(shifted - {1'b0, div_ff}) : shifted[STEP_W-1:0];
         quo_in  = {quo_ff[QUO_W-2:0], fits};
         iter_in = iter_ff + 1'b1;
         if (iter_ff == ITER_W'(QUO_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      iter_ff <= iter_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
   end

   assign status.done      = done_ff;
   assign status.quotient  = quo_ff;
   assign status.remainder = rem_ff;

endmodule

[sv/pointer_event_queue_unit.sv]
// Pointer event queue: pointer state tracking with a drop-oldest event FIFO.
// Depends on peq_pkg, peq_ram and peq_wheel_div.
`timescale 1ns / 1ps

// Usage
//   Request channel: drive req_* with start high; the word is taken at the
//   clock edge where start is high and busy is low. busy stays high while
//   the word is worked on.
//   Move, button, enter and leave: accept, then one queue write.
//   Read: the response word shows on rsp_* with rsp_strobe high
//   for one cycle, the cycle after accept. rsp_event_valid low and all
//   fields zero when the queue was empty.
//   Flush: no response.
//   Wheel: accept, then the bit-serial divider, then one queue write per
//   scroll entry, at most QUEUE_DEPTH entries.
//   The queue memory has one write and one read port, so entries are
//   written or read one at a time.
//   csr channel: wheel_step is written when csr_valid and csr_ready are high;
//   csr_ready is high only while idle. Zero is taken as one.
//   Reset: queue empty, pointer at origin, buttons up, wheel_step 120.
//   Queue contents are not cleared. The receiver cannot stall the response.

module pointer_event_queue_unit
   import peq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [KIND_W-1:0]         req_kind,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [WHEEL_W-1:0] req_wheel_delta,
   output logic                      rsp_strobe,
   output logic                      rsp_event_valid,
   output logic [TYPE_W-1:0]         rsp_event_type,
   output logic signed [COORD_W-1:0] rsp_event_x,
   output logic signed [COORD_W-1:0] rsp_event_y,
   output logic                      rsp_event_left,
   output logic                      rsp_event_right,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [STEP_W-1:0]         csr_wheel_step
);

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [COORD_W-1:0]         cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]         cur_y_ff, cur_y_in;
   logic                       left_ff, left_in;
   logic                       right_ff, right_in;
   logic signed [WHEEL_W-1:0]  carry_ff, carry_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [CNT_W-1:0]           push_left_ff, push_left_in;
   logic [TYPE_W-1:0]          push_type_ff, push_type_in;
   logic                       sign_ff, sign_in;
   logic                       hit_ff, hit_in;

   logic                       wr_en;
   logic                       rd_en;
   logic [IDX_W-1:0]           slot;
   logic [CNT_W:0]             slot_sum;
   logic [IDX_W-1:0]           head_next;
   entry_type                  wr_entry;
   entry_type                  rd_entry;
   logic [ENTRY_W-1:0]         rd_data;

   logic signed [WHEEL_W:0]    wheel_sum;
   logic [WHEEL_W:0]           wheel_abs;
   logic [STEP_W-1:0]          step_eff;
   logic                       div_start;
   div_status_type             div_status;
   logic [CNT_W-1:0]           scroll_n;
   logic [WHEEL_W-1:0]         rem_ext;

   // write slot is (head + count) mod depth; the sum stays below twice the depth
   always_comb begin
      slot_sum  = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
      slot      = (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                ? IDX_W'(slot_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(slot_sum);
      head_next = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   end

   always_comb begin
      wheel_sum = {carry_ff[WHEEL_W-1], carry_ff}
                + {req_wheel_delta[WHEEL_W-1], req_wheel_delta};
      wheel_abs = wheel_sum[WHEEL_W] ? (WHEEL_W+1)'(-wheel_sum) : wheel_sum;
      step_eff  = (step_ff == '0) ? STEP_W'(1) : step_ff;
      scroll_n  = (div_status.quotient > QUO_W'(QUEUE_DEPTH))
                ? CNT_W'(QUEUE_DEPTH) : div_status.quotient[CNT_W-1:0];
      rem_ext   = {1'b0, div_status.remainder};
   end

   peq_wheel_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wheel_abs[WHEEL_W-1:0]),
      .divisor  (step_eff),
      .status   (div_status)
   );

   assign wr_entry.event_type = push_type_ff;
   assign wr_entry.x          = cur_x_ff;
   assign wr_entry.y          = cur_y_ff;
   assign wr_entry.left       = left_ff;
   assign wr_entry.right      = right_ff;

   peq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      carry_in     = carry_ff;
      step_in      = step_ff;
      push_left_in = push_left_ff;
      push_type_in = push_type_ff;
      sign_in      = sign_ff;
      hit_in       = hit_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      div_start    = 1'b0;
      rsp_strobe   = 1'b0;
      busy         = (state_ff != ST_IDLE);
      csr_ready    = (state_ff == ST_IDLE);

      if (csr_valid && csr_ready) begin
         step_in = csr_wheel_step;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               push_left_in = CNT_W'(1);
               unique case (req_kind)
                  KIND_MOVE: begin
                     cur_x_in     = req_pos_x;
                     cur_y_in     = req_pos_y;
                     push_type_in = EVT_MOVE;
                     state_in     = ST_PUSH;
                  end
                  KIND_LPRESS: begin
                     left_in      = 1'b1;
                     push_type_in = EVT_LPRESS;
                     state_in     = ST_PUSH;
                  end
                  KIND_LRELEASE: begin
                     left_in      = 1'b0;
                     push_type_in = EVT_LRELEASE;
                     state_in     = ST_PUSH;
                  end
                  KIND_RPRESS: begin
                     right_in     = 1'b1;
                     push_type_in = EVT_RPRESS;
                     state_in     = ST_PUSH;
                  end
                  KIND_RRELEASE: begin
                     right_in     = 1'b0;
                     push_type_in = EVT_RRELEASE;
                     state_in     = ST_PUSH;
                  end
                  KIND_ENTER: begin
                     push_type_in = EVT_ENTER;
                     state_in     = ST_PUSH;
                  end
                  KIND_LEAVE: begin
                     push_type_in = EVT_LEAVE;
                     state_in     = ST_PUSH;
                  end
                  KIND_WHEEL: begin
                     sign_in   = wheel_sum[WHEEL_W];
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end
                  KIND_READ: begin
                     rd_en    = 1'b1;
                     hit_in   = (count_ff != '0);
                     state_in = ST_READ;
                  end
                  KIND_FLUSH: begin
                     head_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               // remainder carries the sign of the sum, below one step in size
               carry_in     = sign_ff ? -rem_ext : rem_ext;
               push_left_in = scroll_n;
               push_type_in = sign_ff ? EVT_SCROLLDOWN : EVT_SCROLLUP;
               state_in     = (scroll_n == '0) ? ST_IDLE : ST_PUSH;
            end
         end
         ST_PUSH: begin
            wr_en = 1'b1;
            if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
               count_in = count_ff + 1'b1;
            end else begin
               head_in = head_next;   // full: oldest word dropped
            end
            push_left_in = push_left_ff - 1'b1;
            if (push_left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_strobe = 1'b1;
            if (hit_ff) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         left_ff  <= 1'b0;
         right_ff <= 1'b0;
         carry_ff <= '0;
         step_ff  <= WHEEL_STEP_RESET;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         carry_ff <= carry_in;
         step_ff  <= step_in;
      end
      push_left_ff <= push_left_in;
      push_type_ff <= push_type_in;
      sign_ff      <= sign_in;
      hit_ff       <= hit_in;
   end

   always_comb begin
      rsp_event_valid = rsp_strobe && hit_ff;
      rsp_event_type  = rsp_event_valid ? rd_entry.event_type : '0;
      rsp_event_x     = rsp_event_valid ? rd_entry.x : '0;
      rsp_event_y     = rsp_event_valid ? rd_entry.y : '0;
      rsp_event_left  = rsp_event_valid ? rd_entry.left : 1'b0;
      rsp_event_right = rsp_event_valid ? rd_entry.right : 1'b0;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) && ($past(req_kind) == KIND_READ)))
      else $error("response word without a read request");

   a_empty_rsp_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_event_valid) |->
         (rsp_event_type == '0 && rsp_event_x == '0 && rsp_event_y == '0
          && !rsp_event_left && !rsp_event_right))
      else $error("empty read response carries data");

   a_push_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH) |-> (push_left_ff != '0))
      else $error("queue write with no entries left to write");
`endif

endmodule

[tb/sv/tb_top.sv]
// Self-checking bench for pointer_event_queue_unit: directed and random event words,
// with a built-in predictor of the queue, pointer state and wheel carry.
// Depends on peq_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module tb_top;
   import peq_pkg::*;

   // slowest word is a wheel: accept, the divider, up to QUEUE_DEPTH writes
   localparam int SETTLE_CYCLES = 2 + QUO_W + QUEUE_DEPTH + 4;
   localparam int ITEMS_PER_PHASE = 250;

   typedef struct packed {
      logic      valid;
      entry_type ev;
   } read_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [KIND_W-1:0]         req_kind = KIND_MOVE;
   logic signed [COORD_W-1:0] req_pos_x = '0;
   logic signed [COORD_W-1:0] req_pos_y = '0;
   logic signed [WHEEL_W-1:0] req_wheel_delta = '0;
   logic                      rsp_strobe;
   logic                      rsp_event_valid;
   logic [TYPE_W-1:0]         rsp_event_type;
   logic signed [COORD_W-1:0] rsp_event_x;
   logic signed [COORD_W-1:0] rsp_event_y;
   logic                      rsp_event_left;
   logic                      rsp_event_right;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [STEP_W-1:0]         csr_wheel_step = WHEEL_STEP_RESET;

   // predicted state of the block
   entry_type                 queued_events [QUEUE_DEPTH];
   int unsigned               head_slot = 0;
   int unsigned               fill_count = 0;
   logic signed [COORD_W-1:0] ptr_x = '0;
   logic signed [COORD_W-1:0] ptr_y = '0;
   logic                      left_held = 1'b0;
   logic                      right_held = 1'b0;
   int                        wheel_carry = 0;
   logic [STEP_W-1:0]         wheel_step = WHEEL_STEP_RESET;

   read_word_type             pending_reads [$];
   int                        fault_count = 0;
   bit                        idle_enabled = 1'b1;

   pointer_event_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_wheel_delta (req_wheel_delta),
      .rsp_strobe      (rsp_strobe),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_type  (rsp_event_type),
      .rsp_event_x     (rsp_event_x),
      .rsp_event_y     (rsp_event_y),
      .rsp_event_left  (rsp_event_left),
      .rsp_event_right (rsp_event_right),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wheel_step  (csr_wheel_step)
   );

   always #6 clock = ~clock;

   function automatic void push_event(input logic [TYPE_W-1:0] evt);
      int unsigned slot;
      slot = (head_slot + fill_count) % QUEUE_DEPTH;
      queued_events[slot] = '{event_type: evt, x: ptr_x, y: ptr_y,
                              left: left_held, right: right_held};
      if (fill_count < QUEUE_DEPTH) begin
         fill_count++;
      end else begin
         // full: oldest entry goes
         head_slot = (head_slot + 1) % QUEUE_DEPTH;
      end
   endfunction

   function automatic void predict_word(input logic [KIND_W-1:0] kind,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic signed [WHEEL_W-1:0] delta);
      int stp;
      int sum;
      int n;
      case (kind)
         KIND_MOVE: begin
            ptr_x = x;
            ptr_y = y;
            push_event(EVT_MOVE);
         end
         KIND_LPRESS: begin
            left_held = 1'b1;
            push_event(EVT_LPRESS);
         end
         KIND_LRELEASE: begin
            left_held = 1'b0;
            push_event(EVT_LRELEASE);
         end
         KIND_RPRESS: begin
            right_held = 1'b1;
            push_event(EVT_RPRESS);
         end
         KIND_RRELEASE: begin
            right_held = 1'b0;
            push_event(EVT_RRELEASE);
         end
         KIND_ENTER: push_event(EVT_ENTER);
         KIND_LEAVE: push_event(EVT_LEAVE);
         KIND_WHEEL: begin
            stp = (wheel_step == '0) ? 1 : int'(wheel_step);
            sum = wheel_carry + int'(delta);
            if (sum >= stp) begin
               n = sum / stp;
               wheel_carry = sum - n * stp;
               repeat ((n > QUEUE_DEPTH) ? QUEUE_DEPTH : n) push_event(EVT_SCROLLUP);
            end else if (sum <= -stp) begin
               n = (-sum) / stp;
               wheel_carry = sum + n * stp;
               repeat ((n > QUEUE_DEPTH) ? QUEUE_DEPTH : n) push_event(EVT_SCROLLDOWN);
            end else begin
               wheel_carry = sum;
            end
         end
         KIND_READ: begin
            if (fill_count > 0) begin
               pending_reads.push_back('{valid: 1'b1, ev: queued_events[head_slot]});
               head_slot = (head_slot + 1) % QUEUE_DEPTH;
               fill_count--;
            end else begin
               pending_reads.push_back('0);
            end
         end
         KIND_FLUSH: begin
            head_slot = 0;
            fill_count = 0;
         end
         default: ;
      endcase
   endfunction

   // start is left high after acceptance; the next send or rest moves it
   task automatic send_word(input logic [KIND_W-1:0] kind,
                            input logic signed [COORD_W-1:0] x = '0,
                            input logic signed [COORD_W-1:0] y = '0,
                            input logic signed [WHEEL_W-1:0] delta = '0);
      @(negedge clock);
      start <= 1'b1;
      req_kind <= kind;
      req_pos_x <= x;
      req_pos_y <= y;
      req_wheel_delta <= delta;
      do @(posedge clock); while (busy !== 1'b0);
      predict_word(kind, x, y, delta);
   endtask

   task automatic rest(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic maybe_rest();
      if (idle_enabled && $urandom_range(3) == 0)
         rest($urandom_range(18, 1));
   endtask

   task automatic settle();
      int waited;
      waited = 0;
      rest(1);
      while (pending_reads.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_wheel_step(input logic [STEP_W-1:0] value);
      settle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wheel_step <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      wheel_step = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // response checker: the receiver cannot stall, so every strobe is a word
   always @(posedge clock) begin
      read_word_type seen;
      read_word_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         seen = '{valid: rsp_event_valid,
                  ev: '{event_type: rsp_event_type, x: rsp_event_x, y: rsp_event_y,
                        left: rsp_event_left, right: rsp_event_right}};
         if (pending_reads.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected response word at %0t: valid %b type %0d", $realtime,
                        seen.valid, seen.ev.event_type);
         end else begin
            want = pending_reads.pop_front();
            if (seen.valid !== want.valid || seen.ev.event_type !== want.ev.event_type ||
                seen.ev.x !== want.ev.x || seen.ev.y !== want.ev.y ||
                seen.ev.left !== want.ev.left || seen.ev.right !== want.ev.right) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("mismatch at %0t: exp v%b t%0d x%0d y%0d l%b r%b, got v%b t%0d x%0d y%0d l%b r%b",
                           $realtime, want.valid, want.ev.event_type,
                           $signed(want.ev.x), $signed(want.ev.y), want.ev.left,
                           want.ev.right, seen.valid, seen.ev.event_type,
                           $signed(seen.ev.x), $signed(seen.ev.y), seen.ev.left,
                           seen.ev.right);
            end
         end
      end
   end

   // buttons, position extremes, enter/leave, ignored kinds, flush, empty read
   task automatic test_pointer_events();
      send_word(KIND_READ);
      send_word(KIND_MOVE, 16'sh8000, 16'sh7fff);
      send_word(KIND_LPRESS);
      send_word(KIND_RPRESS);
      send_word(KIND_RRELEASE);   // left must stay held
      send_word(KIND_LRELEASE);
      send_word(KIND_ENTER);
      send_word(KIND_LEAVE);
      send_word(KIND_MOVE, 16'sh7fff, 16'sh8000, 16'sh7fff);
      send_word(4'd15, 16'sh7fff, 16'sh7fff, 16'sh8000);
      send_word(KIND_FLUSH + 1'b1);
      repeat (3) send_word(KIND_READ);
      send_word(KIND_FLUSH);
      send_word(KIND_READ);
   endtask

   // wheel carry, overflow of the queue by scroll bursts, step extremes
   task automatic test_wheel_steps();
      send_word(KIND_WHEEL, '0, '0, 16'sd119);
      send_word(KIND_WHEEL, '0, '0, 16'sd1);
      send_word(KIND_WHEEL, '0, '0, -16'sd240);
      repeat (2) send_word(KIND_READ);
      write_wheel_step(15'd1);
      send_word(KIND_WHEEL, '0, '0, 16'sh7fff);
      send_word(KIND_READ);
      send_word(KIND_WHEEL, '0, '0, 16'sh8000);
      write_wheel_step(15'h7fff);
      send_word(KIND_WHEEL, '0, '0, 16'sh7fff);
      send_word(KIND_WHEEL, '0, '0, 16'sh8000);
      write_wheel_step('0);
      send_word(KIND_WHEEL, '0, '0, 16'sd2);
      send_word(KIND_READ);
   endtask

   task automatic test_random_traffic();
      logic [STEP_W-1:0]         phase_steps [6];
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [WHEEL_W-1:0] delta;
      int                        r;
      int                        mag;
      phase_steps = '{WHEEL_STEP_RESET, 15'd1, 15'd0, 15'h7fff,
                      15'($urandom_range(400, 2)), 15'($urandom_range(32767, 1))};
      foreach (phase_steps[p]) begin
         write_wheel_step(phase_steps[p]);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 40 == 0)
               idle_enabled = (p != 5) && ($urandom_range(2) != 0);
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
            delta = WHEEL_W'($urandom);
            r = $urandom_range(99);
            if (r < 18) kind = KIND_MOVE;
            else if (r < 24) kind = KIND_LPRESS;
            else if (r < 30) kind = KIND_LRELEASE;
            else if (r < 36) kind = KIND_RPRESS;
            else if (r < 42) kind = KIND_RRELEASE;
            else if (r < 45) kind = KIND_ENTER;
            else if (r < 48) kind = KIND_LEAVE;
            else if (r < 62) kind = KIND_WHEEL;
            else if (r < 94) kind = KIND_READ;
            else if (r < 97) kind = KIND_FLUSH;
            else kind = KIND_W'($urandom_range(15, KIND_FLUSH + 1));
            // half the wheel words sized around the step so bursts stay small
            if (kind == KIND_WHEEL && $urandom_range(1) == 0) begin
               mag = $urandom_range(int'(wheel_step) * 3 + 2);
               if (mag > 32767) mag = 32767;
               delta = WHEEL_W'(($urandom_range(1) == 0) ? mag : -mag);
            end
            send_word(kind, x, y, delta);
            maybe_rest();
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_pointer_events();
      test_wheel_steps();
      test_random_traffic();
      settle();
      fault_count += pending_reads.size();
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #(12 * 800000);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
